FILE: design/ymodem_block_sender_unit_defines.svh
// Shared assertion macros for the block sender checker.
`ifndef YMODEM_BLOCK_SENDER_UNIT_DEFINES_SVH
`define YMODEM_BLOCK_SENDER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define YBS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define YBS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: design/ybs_pkg.sv
// ----------------------------------------------------------------------------
// ybs_pkg
// Types, codes and the CRC helper shared by the block sender modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ybs_pkg;
  localparam int BLOCK_BYTES = 128;
  localparam int IDX_W = $clog2(BLOCK_BYTES);
  localparam int POS_W = $clog2(BLOCK_BYTES + 5);

  typedef enum logic [3:0] {
    PH_IDLE, PH_BLK_TX, PH_BLK_WAIT, PH_EOT1_TX, PH_EOT1_WAIT,
    PH_EOT2_TX, PH_EOT2_WAIT, PH_REQ_WAIT, PH_CAN_TX, PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    OP_LOAD, OP_PARTNER, OP_TICK, OP_SLOT, OP_SEND_BLOCK, OP_SEND_EOT,
    OP_WAIT_REQ, OP_CANCEL
  } op_t;

  typedef enum logic [1:0] {
    REG_REPLY_TIMEOUT, REG_POLL_PERIOD, REG_RETRY_LIMIT, REG_DRAIN
  } reg_idx_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CANCELED = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_REQ = 8'h43;
  localparam logic [7:0] B_ETX = 8'h03;
  localparam logic [7:0] B_SUB = 8'h1a;
  localparam logic [7:0] B_NUL = 8'h00;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [6:0] buffer_index;
    logic       restart_sequence;
    logic [7:0] wait_limit;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
    logic [7:0] sequence_res;
  } out_item_t;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

FILE: design/ybs_buffer.sv
// ----------------------------------------------------------------------------
// ybs_buffer
// Block buffer memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ybs_buffer (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ybs_pkg::IDX_W-1:0]  wr_addr,
  input  wire logic [7:0]                 wr_data,
  input  wire logic [ybs_pkg::IDX_W-1:0]  rd_addr,
  output logic      [7:0]                 rd_data
);
  logic [7:0] mem [ybs_pkg::BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: design/ymodem_block_sender_unit.sv
// ----------------------------------------------------------------------------
// ymodem_block_sender_unit
// YMODEM sender: frames 128-byte blocks with CRC-16 and runs the handshakes.
// ----------------------------------------------------------------------------
// Usage: every input transaction carries an operation (load byte, partner
// byte, millisecond tick, transmit slot, send block, send EOT, wait request
// or cancel). Each transaction produces zero or one result transaction: a byte
// to transmit or a finish status with the current sequence number.
// An accepted transaction is held in an input register while the buffer
// memory is read, then the state update and the result are computed and
// the result is placed in the output register. One transaction is accepted
// per cycle; the rate is set by the single result register, so in_ready
// drops only when the output register is full and the receiver stalls it.
// The buffer read for the next frame byte is issued when the item enters the
// input register, so consecutive transmit slots still run back to back.
// Reset (rst_n low, synchronous) returns the block to idle, zeroes the
// sequence and loads the register reset values; the buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module ymodem_block_sender_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire ybs_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ybs_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata
);
  // Configuration registers.
  logic [15:0] reply_to_r, poll_r, drain_r;
  logic [7:0]  retry_r;

  // State registers.
  ybs_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [ybs_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] el_r, el_nxt;
  logic [7:0]  att_r, att_nxt, cap_r, cap_nxt;

  // Input stage.
  logic               s1_valid_r;
  ybs_pkg::in_item_t  s1_r;
  logic               ov_r;
  ybs_pkg::out_item_t od_r;
  logic               res_v;
  ybs_pkg::out_item_t res;

  // Stage 1 advances whenever the output register can take its result.
  logic adv;
  assign adv = !ov_r || out_ready;
  assign in_ready = adv;
  assign out_valid = ov_r;
  assign out_data = od_r;

  // Buffer read address: the data position the next slot will need. When a
  // slot is in stage 1 and advances, the following position is pos_r + 1.
  logic [7:0] rd_pos;
  logic [ybs_pkg::IDX_W-1:0] rd_addr;
  logic [7:0] rd_data;
  assign rd_pos = 8'(adv ? pos_nxt : pos_r) - 8'd3;
  assign rd_addr = rd_pos[ybs_pkg::IDX_W-1:0];

  // Loads in stage 1 write the buffer; a read of the same address in the same
  // cycle is forwarded.
  logic wr_en;
  assign wr_en = s1_valid_r && adv && s1_r.operation == ybs_pkg::OP_LOAD;

  ybs_buffer u_buf (
    .clk(clk), .wr_en(wr_en), .wr_addr(s1_r.buffer_index),
    .wr_data(s1_r.data_byte), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic       fwd_r;
  logic [7:0] fwd_data_r;
  logic [7:0] buf_byte;
  always_ff @(posedge clk) begin
    fwd_r <= wr_en && s1_r.buffer_index == rd_addr;
    fwd_data_r <= s1_r.data_byte;
  end
  assign buf_byte = fwd_r ? fwd_data_r : rd_data;
  // When stage 1 stalls the read address holds, so the read data stays valid.

  // Next state and result for the item in stage 1.
  always_comb begin
    logic [15:0] limit;
    logic [15:0] el_inc;
    logic        do_fail, to_blk, wait_ph;
    logic [7:0]  att_inc;
    logic [1:0]  fst;
    logic        fin;
    logic [7:0]  b;
    phase_nxt = phase_r; seq_nxt = seq_r; pos_nxt = pos_r; crc_nxt = crc_r;
    el_nxt = el_r; att_nxt = att_r; cap_nxt = cap_r;
    res_v = 1'b0; fin = 1'b0; fst = ybs_pkg::ST_OK; b = 8'h00;
    do_fail = 1'b0; to_blk = 1'b0;
    limit = reply_to_r; el_inc = el_r + 16'd1; att_inc = att_r + 8'd1;
    wait_ph = 1'b0;
    if (s1_valid_r) begin
      case (s1_r.operation) inside
        ybs_pkg::OP_PARTNER: begin
          case (phase_r)
            ybs_pkg::PH_BLK_WAIT: begin
              if (s1_r.data_byte == ybs_pkg::B_ACK) begin
                seq_nxt = seq_r + 8'd1; fin = 1'b1;
              end else if (s1_r.data_byte == ybs_pkg::B_CAN) begin
                fin = 1'b1; fst = ybs_pkg::ST_CANCELED;
              end else begin
                do_fail = 1'b1; to_blk = 1'b1;
              end
            end
            ybs_pkg::PH_EOT1_WAIT: begin
              if (s1_r.data_byte == ybs_pkg::B_ACK) fin = 1'b1;
              else if (s1_r.data_byte == ybs_pkg::B_CAN) begin
                fin = 1'b1; fst = ybs_pkg::ST_CANCELED;
              end else if (s1_r.data_byte == ybs_pkg::B_NAK) begin
                phase_nxt = ybs_pkg::PH_EOT2_TX; el_nxt = '0;
              end else do_fail = 1'b1;
            end
            ybs_pkg::PH_EOT2_WAIT: begin
              if (s1_r.data_byte == ybs_pkg::B_ACK) fin = 1'b1;
              else if (s1_r.data_byte == ybs_pkg::B_CAN) begin
                fin = 1'b1; fst = ybs_pkg::ST_CANCELED;
              end else do_fail = 1'b1;
            end
            ybs_pkg::PH_REQ_WAIT: begin
              if (s1_r.data_byte == ybs_pkg::B_REQ) fin = 1'b1;
              else if (s1_r.data_byte == ybs_pkg::B_CAN ||
                       s1_r.data_byte == ybs_pkg::B_NUL ||
                       s1_r.data_byte == ybs_pkg::B_ETX ||
                       s1_r.data_byte == ybs_pkg::B_SUB) begin
                fin = 1'b1; fst = ybs_pkg::ST_CANCELED;
              end else begin
                el_nxt = '0; wait_ph = 1'b1;
                if (cap_r != 8'd0) do_fail = 1'b1;
              end
            end
            ybs_pkg::PH_DRAIN: fin = 1'b1;
            default: ;
          endcase
        end
        ybs_pkg::OP_TICK: begin
          if (phase_r == ybs_pkg::PH_BLK_WAIT || phase_r == ybs_pkg::PH_EOT1_WAIT ||
              phase_r == ybs_pkg::PH_EOT2_WAIT || phase_r == ybs_pkg::PH_REQ_WAIT ||
              phase_r == ybs_pkg::PH_DRAIN) begin
            if (phase_r == ybs_pkg::PH_REQ_WAIT) limit = poll_r;
            else if (phase_r == ybs_pkg::PH_DRAIN) limit = drain_r;
            if (el_inc < limit) el_nxt = el_inc;
            else begin
              el_nxt = '0;
              case (phase_r)
                ybs_pkg::PH_BLK_WAIT: begin do_fail = 1'b1; to_blk = 1'b1; end
                ybs_pkg::PH_REQ_WAIT: begin
                  wait_ph = 1'b1;
                  if (cap_r != 8'd0) do_fail = 1'b1;
                end
                ybs_pkg::PH_DRAIN: fin = 1'b1;
                default: do_fail = 1'b1;
              endcase
            end
          end
        end
        ybs_pkg::OP_SLOT: begin
          case (phase_r)
            ybs_pkg::PH_BLK_TX: begin
              res_v = 1'b1;
              pos_nxt = pos_r + 1'b1;
              if (pos_r == '0) begin
                crc_nxt = '0;
                b = (ybs_pkg::BLOCK_BYTES == 1024) ? ybs_pkg::B_STX : ybs_pkg::B_SOH;
              end else if (pos_r == ybs_pkg::POS_W'(1)) b = seq_r;
              else if (pos_r == ybs_pkg::POS_W'(2)) b = ~seq_r;
              else if (pos_r < ybs_pkg::POS_W'(3 + ybs_pkg::BLOCK_BYTES)) begin
                b = buf_byte; crc_nxt = ybs_pkg::crc_step(crc_r, buf_byte);
              end else if (pos_r == ybs_pkg::POS_W'(3 + ybs_pkg::BLOCK_BYTES))
                b = crc_r[15:8];
              else begin
                b = crc_r[7:0]; phase_nxt = ybs_pkg::PH_BLK_WAIT; el_nxt = '0;
              end
            end
            ybs_pkg::PH_EOT1_TX: begin
              res_v = 1'b1; b = ybs_pkg::B_EOT;
              phase_nxt = ybs_pkg::PH_EOT1_WAIT; el_nxt = '0;
            end
            ybs_pkg::PH_EOT2_TX: begin
              res_v = 1'b1; b = ybs_pkg::B_EOT;
              phase_nxt = ybs_pkg::PH_EOT2_WAIT; el_nxt = '0;
            end
            ybs_pkg::PH_CAN_TX: begin
              res_v = 1'b1; b = ybs_pkg::B_CAN;
              if (pos_r == '0) pos_nxt = ybs_pkg::POS_W'(1);
              else begin
                pos_nxt = '0; phase_nxt = ybs_pkg::PH_DRAIN; el_nxt = '0;
              end
            end
            default: ;
          endcase
        end
        ybs_pkg::OP_SEND_BLOCK, ybs_pkg::OP_SEND_EOT, ybs_pkg::OP_WAIT_REQ,
        ybs_pkg::OP_CANCEL: begin
          if (phase_r == ybs_pkg::PH_IDLE || s1_r.operation == ybs_pkg::OP_CANCEL) begin
            pos_nxt = '0; crc_nxt = '0; el_nxt = '0; att_nxt = '0;
            case (s1_r.operation)
              ybs_pkg::OP_SEND_BLOCK: begin
                phase_nxt = ybs_pkg::PH_BLK_TX; cap_nxt = retry_r;
                if (s1_r.restart_sequence) seq_nxt = '0;
              end
              ybs_pkg::OP_SEND_EOT: begin
                phase_nxt = ybs_pkg::PH_EOT1_TX; cap_nxt = retry_r;
              end
              ybs_pkg::OP_WAIT_REQ: begin
                phase_nxt = ybs_pkg::PH_REQ_WAIT; cap_nxt = s1_r.wait_limit;
              end
              default: begin
                phase_nxt = ybs_pkg::PH_CAN_TX; cap_nxt = '0;
              end
            endcase
          end
        end
        default: ;
      endcase
      if (do_fail) begin
        att_nxt = att_inc;
        if (att_inc >= cap_r || cap_r == 8'd0) begin
          fin = 1'b1; fst = ybs_pkg::ST_TIMEOUT;
        end else begin
          phase_nxt = to_blk ? ybs_pkg::PH_BLK_TX :
                      (wait_ph ? ybs_pkg::PH_REQ_WAIT : ybs_pkg::PH_EOT1_TX);
          pos_nxt = '0; el_nxt = '0;
        end
      end
      if (fin) begin
        phase_nxt = ybs_pkg::PH_IDLE; pos_nxt = '0; el_nxt = '0; res_v = 1'b1;
      end
    end
    res.kind = fin;
    res.tx_byte = fin ? 8'h00 : b;
    res.status = fin ? fst : ybs_pkg::ST_OK;
    res.sequence_res = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_to_r <= 16'd5000; poll_r <= 16'd1000; retry_r <= 8'd5; drain_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (ybs_pkg::reg_idx_t'(cfg_index))
        ybs_pkg::REG_REPLY_TIMEOUT: reply_to_r <= cfg_wdata;
        ybs_pkg::REG_POLL_PERIOD:   poll_r <= cfg_wdata;
        ybs_pkg::REG_RETRY_LIMIT:   retry_r <= cfg_wdata[7:0];
        ybs_pkg::REG_DRAIN:         drain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ybs_pkg::PH_IDLE; seq_r <= '0; pos_r <= '0; crc_r <= '0;
      el_r <= '0; att_r <= '0; cap_r <= '0; s1_valid_r <= 1'b0; ov_r <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt; seq_r <= seq_nxt; pos_r <= pos_nxt; crc_r <= crc_nxt;
      el_r <= el_nxt; att_r <= att_nxt; cap_r <= cap_nxt;
      s1_valid_r <= in_valid;
      ov_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_data;
      od_r <= res;
    end
  end
endmodule
`default_nettype wire

FILE: design/ybs_checker.sv
// ----------------------------------------------------------------------------
// ybs_checker
// Port-level checks for the block sender.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ymodem_block_sender_unit_defines.svh"
module ybs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ybs_pkg::out_item_t out_data
);
  `YBS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `YBS_ASSERT_IMPL(a_ready_free, clk, rst_n, !out_valid, in_ready)
  `YBS_ASSERT_IMPL(a_fin_clean, clk, rst_n, out_valid && out_data.kind, out_data.tx_byte == 8'h00)
  `YBS_ASSERT_IMPL(a_byte_ok, clk, rst_n, out_valid && !out_data.kind, out_data.status == ybs_pkg::ST_OK)
endmodule

bind ymodem_block_sender_unit ybs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YMODEM block sender: block, EOT, request-wait
// and cancel sessions with random partner replies, ticks and throttling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import ybs_pkg::*;

  // Behavioral copy of the sender plus a queue of expected result transactions.
  class sender_scoreboard;
    logic [15:0] reply_to, poll_to, drain_to;
    logic [7:0] retry_lim;
    phase_t ph;
    logic [7:0] seq_no;
    logic [7:0] buf_mem [BLOCK_BYTES];
    int unsigned fpos;
    logic [15:0] crc, elapsed;
    logic [7:0] tries, cap;
    out_item_t pending_q [$];
    int unsigned mismatches, checked;

    function void reset_state();
      reply_to = 16'd5000; poll_to = 16'd1000; retry_lim = 8'd5; drain_to = 16'd1000;
      ph = PH_IDLE; seq_no = '0; fpos = 0; crc = '0; elapsed = '0;
      tries = '0; cap = '0;
      for (int i = 0; i < BLOCK_BYTES; i++) buf_mem[i] = '0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_REPLY_TIMEOUT: reply_to = v;
        REG_POLL_PERIOD:   poll_to = v;
        REG_RETRY_LIMIT:   retry_lim = v[7:0];
        default:           drain_to = v;
      endcase
    endfunction

    function void push_byte(logic [7:0] b);
      out_item_t r;
      r.kind = 1'b0; r.tx_byte = b; r.status = ST_OK; r.sequence_res = seq_no;
      pending_q.push_back(r);
    endfunction

    function void done(logic [1:0] st);
      out_item_t r;
      ph = PH_IDLE; fpos = 0; elapsed = '0;
      r.kind = 1'b1; r.tx_byte = '0; r.status = st; r.sequence_res = seq_no;
      pending_q.push_back(r);
    endfunction

    function void crc_add(logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      crc = c;
    endfunction

    function void miss(phase_t again);
      tries = tries + 8'd1;
      if (tries >= cap || cap == 0) done(ST_TIMEOUT);
      else begin
        ph = again; fpos = 0; elapsed = '0;
      end
    endfunction

    function void begin_op(phase_t p, logic [7:0] c);
      ph = p; fpos = 0; crc = '0; elapsed = '0; tries = '0; cap = c;
    endfunction

    // Notes one accepted input transaction and queues what it should produce.
    function void note_input(in_item_t it);
      logic [15:0] lim;
      logic [7:0] b;
      b = it.data_byte;
      case (op_t'(it.operation))
        OP_LOAD: buf_mem[it.buffer_index] = b;
        OP_PARTNER: begin
          case (ph)
            PH_BLK_WAIT:
              if (b == B_ACK) begin
                seq_no = seq_no + 8'd1; done(ST_OK);
              end else if (b == B_CAN) done(ST_CANCELED);
              else miss(PH_BLK_TX);
            PH_EOT1_WAIT:
              if (b == B_ACK) done(ST_OK);
              else if (b == B_CAN) done(ST_CANCELED);
              else if (b == B_NAK) begin
                ph = PH_EOT2_TX; elapsed = '0;
              end else miss(PH_EOT1_TX);
            PH_EOT2_WAIT:
              if (b == B_CAN) done(ST_CANCELED);
              else if (b == B_ACK) done(ST_OK);
              else miss(PH_EOT1_TX);
            PH_REQ_WAIT:
              if (b == B_REQ) done(ST_OK);
              else if (b == B_CAN || b == B_NUL || b == B_ETX || b == B_SUB)
                done(ST_CANCELED);
              else begin
                elapsed = '0;
                if (cap != 0) miss(PH_REQ_WAIT);
              end
            PH_DRAIN: done(ST_OK);
            default: ;
          endcase
        end
        OP_TICK: begin
          if (ph inside {PH_BLK_WAIT, PH_EOT1_WAIT, PH_EOT2_WAIT, PH_REQ_WAIT,
                         PH_DRAIN}) begin
            lim = (ph == PH_REQ_WAIT) ? poll_to : (ph == PH_DRAIN) ? drain_to : reply_to;
            elapsed = elapsed + 16'd1;
            if (elapsed >= lim) begin
              elapsed = '0;
              if (ph == PH_BLK_WAIT) miss(PH_BLK_TX);
              else if (ph == PH_EOT1_WAIT || ph == PH_EOT2_WAIT) miss(PH_EOT1_TX);
              else if (ph == PH_REQ_WAIT) begin
                if (cap != 0) miss(PH_REQ_WAIT);
              end else done(ST_OK);
            end
          end
        end
        OP_SLOT: begin
          case (ph)
            PH_BLK_TX: begin
              if (fpos == 0) begin
                crc = '0; push_byte(BLOCK_BYTES == 1024 ? B_STX : B_SOH);
              end else if (fpos == 1) push_byte(seq_no);
              else if (fpos == 2) push_byte(~seq_no);
              else if (fpos < 3 + BLOCK_BYTES) begin
                crc_add(buf_mem[fpos-3]); push_byte(buf_mem[fpos-3]);
              end else if (fpos == 3 + BLOCK_BYTES) push_byte(crc[15:8]);
              else begin
                ph = PH_BLK_WAIT; elapsed = '0; push_byte(crc[7:0]);
              end
              fpos++;
            end
            PH_EOT1_TX: begin
              ph = PH_EOT1_WAIT; elapsed = '0; push_byte(B_EOT);
            end
            PH_EOT2_TX: begin
              ph = PH_EOT2_WAIT; elapsed = '0; push_byte(B_EOT);
            end
            PH_CAN_TX: begin
              if (fpos == 0) fpos = 1;
              else begin
                fpos = 0; ph = PH_DRAIN; elapsed = '0;
              end
              push_byte(B_CAN);
            end
            default: ;
          endcase
        end
        OP_SEND_BLOCK:
          if (ph == PH_IDLE) begin
            if (it.restart_sequence) seq_no = '0;
            begin_op(PH_BLK_TX, retry_lim);
          end
        OP_SEND_EOT: if (ph == PH_IDLE) begin_op(PH_EOT1_TX, retry_lim);
        OP_WAIT_REQ: if (ph == PH_IDLE) begin_op(PH_REQ_WAIT, it.wait_limit);
        default: begin_op(PH_CAN_TX, 8'd0);
      endcase
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected kind %0d byte %h st %0d seq %h, got kind %0d byte %h st %0d seq %h",
                   want.kind, want.tx_byte, want.status, want.sequence_res,
                   got.kind, got.tx_byte, got.status, got.sequence_res);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  sender_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int unsigned quiet_cycles, sent_items;
  bit hold_off;

  ymodem_block_sender_unit uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both checks sample at the rising edge; drivers change after it.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random readiness, or a long stall while the hold-off is on.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles where no transaction moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one item, with a random gap first, and waits for its acceptance.
  // Valid stays high after acceptance; the gap or the caller lowers it.
  task automatic send_item(input op_t op, input logic [7:0] b, input logic [6:0] idx,
                           input logic rs, input logic [7:0] wl);
    in_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.operation = op; it.data_byte = b; it.buffer_index = idx;
    it.restart_sequence = rs; it.wait_limit = wl;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic rand_item();
    send_item(op_t'($urandom_range(7)), 8'($urandom), 7'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  // Waits for every expected result, then lets in-flight work settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(input reg_idx_t idx, input logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Partner reply, weighted toward the protocol bytes.
  function automatic logic [7:0] reply_byte();
    case ($urandom_range(9)) inside
      [0:2]: return B_ACK;
      3: return B_NAK;
      4: return B_CAN;
      5: return B_REQ;
      6: return B_SUB;
      default: return 8'($urandom);
    endcase
  endfunction

  // One well-formed session with random content and the odd stray item.
  task automatic session();
    int kind, steps;
    kind = $urandom_range(9);
    if (kind < 5) begin
      repeat ($urandom_range(4)) send_item(OP_LOAD, 8'($urandom), 7'($urandom), 0, 0);
      send_item(OP_SEND_BLOCK, 0, 0, 1'($urandom_range(3) == 0), 0);
    end else if (kind < 7) send_item(OP_SEND_EOT, 0, 0, 0, 0);
    else if (kind < 9) send_item(OP_WAIT_REQ, 0, 0, 0, 8'($urandom_range(3)));
    else send_item(OP_CANCEL, 8'($urandom), 0, 0, 0);
    steps = 0;
    while (sb.ph != PH_IDLE && steps < 600) begin
      if ($urandom_range(49) == 0) rand_item();
      else if (sb.ph inside {PH_BLK_TX, PH_EOT1_TX, PH_EOT2_TX, PH_CAN_TX})
        send_item(OP_SLOT, 0, 0, 0, 0);
      else if ($urandom_range(2) == 0) send_item(OP_PARTNER, reply_byte(), 0, 0, 0);
      else send_item(OP_TICK, 0, 0, 0, 0);
      steps++;
    end
  endtask

  task automatic apply_setting(input int s);
    drain_results();
    case (s)
      0: begin
        write_cfg(REG_REPLY_TIMEOUT, 16'd3); write_cfg(REG_POLL_PERIOD, 16'd2);
        write_cfg(REG_RETRY_LIMIT, 8'd3); write_cfg(REG_DRAIN, 16'd2);
      end
      1: begin
        write_cfg(REG_REPLY_TIMEOUT, 16'd1); write_cfg(REG_POLL_PERIOD, 16'd1);
        write_cfg(REG_RETRY_LIMIT, 8'd1); write_cfg(REG_DRAIN, 16'd0);
      end
      2: begin
        write_cfg(REG_REPLY_TIMEOUT, 16'hFFFF); write_cfg(REG_POLL_PERIOD, 16'hFFFF);
        write_cfg(REG_RETRY_LIMIT, 8'hFF); write_cfg(REG_DRAIN, 16'hFFFF);
      end
      default: begin
        write_cfg(REG_REPLY_TIMEOUT, 16'($urandom_range(1, 5)));
        write_cfg(REG_POLL_PERIOD, 16'($urandom_range(1, 4)));
        write_cfg(REG_RETRY_LIMIT, 8'($urandom_range(1, 4)));
        write_cfg(REG_DRAIN, 16'($urandom_range(0, 3)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0;
    cfg_index = '0; cfg_wdata = '0; hold_off = 1'b0; out_ready = 1'b0;
    send_idle_pct = 30; recv_idle_pct = 55; sent_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The whole buffer is written once so no frame reads an unwritten entry.
    for (int i = 0; i < BLOCK_BYTES; i++)
      send_item(OP_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 7'(i), 0, 0);

    // Directed: the reset register values, stray events and busy starts.
    send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_PARTNER, B_ACK, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_SEND_BLOCK, 0, 0, 1, 0);
    send_item(OP_SEND_EOT, 0, 0, 0, 0);
    send_item(OP_LOAD, 8'hFF, 7'd127, 0, 0);
    repeat (BLOCK_BYTES + 5) send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_PARTNER, B_ACK, 0, 0, 0);
    apply_setting(1);
    // EOT with NAK then a timeout retry; retry limit one ends on timeout.
    send_item(OP_SEND_EOT, 0, 0, 0, 0);
    send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_PARTNER, B_NAK, 0, 0, 0);
    send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);
    // Wait forever with bytes that do not end it, then the abort bytes.
    send_item(OP_WAIT_REQ, 0, 0, 0, 8'd0);
    send_item(OP_TICK, 0, 0, 0, 0);
    send_item(OP_PARTNER, 8'h55, 0, 0, 0);
    send_item(OP_PARTNER, B_ETX, 0, 0, 0);
    send_item(OP_WAIT_REQ, 0, 0, 0, 8'hFF);
    send_item(OP_PARTNER, B_NUL, 0, 0, 0);
    // Cancel with zero drain ends on the first tick.
    send_item(OP_CANCEL, 0, 0, 0, 0);
    send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0);

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      if (phase_no == 1) begin
        send_idle_pct = 55; recv_idle_pct = 30;
      end else if (phase_no == 2) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      for (int k = 0; k < 4; k++) begin
        apply_setting((k == 0) ? phase_no : 3);
        while (sent_items < 200 + phase_no * 550 + (k + 1) * 135) session();
      end
    end

    // Long receiver stall while the sender keeps feeding a frame.
    drain_results();
    send_idle_pct = 0;
    send_item(OP_SEND_BLOCK, 0, 0, 0, 0);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (40) send_item(OP_SLOT, 0, 0, 0, 0);
    join
    send_item(OP_CANCEL, 0, 0, 0, 0);
    repeat (2) send_item(OP_SLOT, 0, 0, 0, 0);
    send_item(OP_PARTNER, 8'h00, 0, 0, 0);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d input transactions, checked %0d results, %0d mismatches.",
             sent_items, sb.checked, sb.mismatches);
    $display("Covered block frames, EOT, request waits, cancel/drain and stalls.");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
